// ----- src/rbp_pkg.sv -----
// Package for the radial brush painter: shared widths, constants and the
// control structs passed between the sequencer and the square-root/divide unit.
// No dependencies.
package rbp_pkg;

    // Width of the image size registers and of pixel indices.
    localparam int DIM_W = 9;
    // Q.16 coordinate width: a Q0.16 value times a 9-bit dimension.
    localparam int QW = 25;
    // Width of a squared distance and of the square-root operand.
    localparam int D2W = 52;
    // Width of the normalized distance, which reaches 1.0 in Q0.16.
    localparam int SW = 17;
    // Multiplier operand and product widths.
    localparam int MUL_W = 32;
    localparam int PROD_W = 64;

    localparam logic [SW-1:0] ONE_Q16 = 17'h10000;

    localparam int DEF_MAX_WIDTH = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    typedef struct packed {
        logic           start;
        logic [D2W-1:0] d2;
        logic [QW-1:0]  r;
    } t_sd_req;

    typedef struct packed {
        logic          done;
        logic [SW-1:0] s;
    } t_sd_stat;

endpackage

// ----- src/rbp_in_if.sv -----
// Input channel of the radial brush painter: valid/ready plus one command.
// Depends on rbp_pkg.
interface rbp_in_if;
    import rbp_pkg::*;

    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] center_u;
    logic [15:0] center_v;
    logic [15:0] brush_radius;
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
    logic [7:0]  color_alpha;
    logic [7:0]  read_x;
    logic [7:0]  read_y;

    modport source (
        output valid, func, center_u, center_v, brush_radius,
        output color_red, color_green, color_blue, color_alpha, read_x, read_y,
        input  ready
    );
    modport sink (
        input  valid, func, center_u, center_v, brush_radius,
        input  color_red, color_green, color_blue, color_alpha, read_x, read_y,
        output ready
    );
endinterface

// ----- src/rbp_out_if.sv -----
// Result channel of the radial brush painter: valid/ready plus one result.
// Depends on rbp_pkg.
interface rbp_out_if;
    import rbp_pkg::*;

    logic        valid;
    logic        ready;
    logic [31:0] pixel_rgba;
    logic [7:0]  region_x;
    logic [7:0]  region_y;
    logic [DIM_W-1:0] region_w;
    logic [DIM_W-1:0] region_h;

    modport source (
        output valid, pixel_rgba, region_x, region_y, region_w, region_h,
        input  ready
    );
    modport sink (
        input  valid, pixel_rgba, region_x, region_y, region_w, region_h,
        output ready
    );
endinterface

// ----- src/rbp_mult.sv -----
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on rbp_pkg.
module rbp_mult (
    input  logic                       i_clk,
    input  logic [rbp_pkg::MUL_W-1:0]  i_a,
    input  logic [rbp_pkg::MUL_W-1:0]  i_b,
    output logic [rbp_pkg::PROD_W-1:0] o_prod
);
    import rbp_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;
endmodule

// ----- src/rbp_store.sv -----
// Pixel store: one write port and one registered read port, 32-bit words.
// Depends on nothing outside this file.
module rbp_store #(
    parameter int DEPTH = 65536,
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);
    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/rbp_sqrt_div.sv -----
// Iterative unit: integer square root of a squared distance, two bits a cycle,
// then the root divided by the radius into Q0.16, one quotient bit a cycle.
// Depends on rbp_pkg.
module rbp_sqrt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbp_pkg::t_sd_req  i_req,
    output rbp_pkg::t_sd_stat o_stat
);
    import rbp_pkg::*;

    localparam int CW = $clog2(SW);

    typedef enum logic [1:0] {SD_IDLE, SD_SQRT, SD_DIV, SD_DONE} t_sd_state;

    t_sd_state      r_state;
    logic [D2W-1:0] r_n;
    logic [D2W-1:0] r_root;
    logic [D2W-1:0] r_bit;
    logic [QW-1:0]  r_r;
    logic [QW:0]    r_rem;
    logic [SW-1:0]  r_q;
    logic [CW-1:0]  r_cnt;

    logic [D2W-1:0] sum;
    logic           sq_ge;
    logic [D2W-1:0] root_nx;
    logic           dv_ge;
    logic [QW:0]    rem_sub;

    always_comb begin
        sum     = r_root + r_bit;
        sq_ge   = (r_n >= sum);
        root_nx = sq_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);
        dv_ge   = (r_rem >= {1'b0, r_r});
        rem_sub = dv_ge ? (r_rem - {1'b0, r_r}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SD_IDLE;
        end else begin
            unique case (r_state)
                SD_IDLE: begin
                    if (i_req.start) begin
                        r_n    <= i_req.d2;
                        r_r    <= i_req.r;
                        r_root <= '0;
                        r_bit  <= D2W'(1) << (D2W - 2);
                        r_q    <= '0;
                        r_cnt  <= '0;
                        // A zero radius only ever covers the center: full weight.
                        r_state <= (i_req.r == '0) ? SD_DONE : SD_SQRT;
                    end
                end
                SD_SQRT: begin
                    if (sq_ge) begin
                        r_n <= r_n - sum;
                    end
                    r_root <= root_nx;
                    r_bit  <= r_bit >> 2;
                    if (r_bit == D2W'(1)) begin
                        r_rem   <= root_nx[QW:0];
                        r_state <= SD_DIV;
                    end
                end
                SD_DIV: begin
                    r_q   <= {r_q[SW-2:0], dv_ge};
                    r_rem <= {rem_sub[QW-1:0], 1'b0};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(SW - 1)) begin
                        r_state <= SD_DONE;
                    end
                end
                SD_DONE: begin
                    r_state <= SD_IDLE;
                end
                default: r_state <= SD_IDLE;
            endcase
        end
    end

    assign o_stat.done = (r_state == SD_DONE);
    assign o_stat.s    = r_q;
endmodule

// ----- src/radial_brush_painter.sv -----
// Top level of the radial brush painter: command sequencer, shared multiplier,
// pixel store and square-root/divide unit. Depends on rbp_pkg and the channel
// interfaces, rbp_mult, rbp_store and rbp_sqrt_div.
//
// Usage. Commands arrive on i_in (valid/ready); each transfer carries one
// command: paint a round brush, fill the whole image, or read one pixel.
// Every command produces exactly one result on o_out, which holds the pixel
// read (zero otherwise) and the region of the image that changed.
// i_cfg_we/i_cfg_idx/i_cfg_data set the width (index 0) and height (1); the
// user must set the image size only while no command is in flight, unenforced.
//
// Operation. The block works on one command at a time and lowers ready
// until it is done. A read forms the address with the multiplier and then
// reads the store once; a fill writes all W*H pixels, one store write per
// cycle; a paint sets up its center, radius and clamped bounding box, then
// tests each pixel of the box and blends only those inside the circle. A
// blended pixel passes through the square-root/divide unit (26 root steps
// plus 17 quotient steps) and uses the single multiplier nine times.
//
// Reset clears the sequencer, the output valid and the size registers (256 x
// 256); the store itself is not cleared and must be filled before it is read.
// When the receiver stalls, the result waits in the output register and the
// next command is still taken; that command's result waits until it drains.
module radial_brush_painter #(
    parameter int MAX_WIDTH = rbp_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rbp_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rbp_in_if.sink                    i_in,
    rbp_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [rbp_pkg::DIM_W-1:0] i_cfg_data
);
    import rbp_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic       CFG_WIDTH  = 1'b0;
    localparam logic       CFG_HEIGHT = 1'b1;
    localparam logic [1:0] FUNC_PAINT = 2'd0;
    localparam logic [1:0] FUNC_FILL  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // 255 * 2^32 - 1, the rounding offset for the downward blend.
    localparam logic [PROD_W-1:0] DEN_M1 = 64'h0000_00FE_FFFF_FFFF;

    typedef enum logic [4:0] {
        ST_IDLE, ST_F_N, ST_F_SET, ST_F_RUN, ST_R_ADDR, ST_R_RD, ST_R_CAP,
        ST_P_CX, ST_P_CY, ST_P_R, ST_P_R2, ST_P_BOX, ST_P_BASE, ST_P_DX,
        ST_P_DY, ST_P_CMP, ST_P_SD, ST_P_T2, ST_P_DA, ST_P_M, ST_P_BL,
        ST_P_WR, ST_P_NEXT, ST_DONE
    } t_state;

    t_state r_state;

    // Configuration.
    logic [DIM_W-1:0] r_cfg_w;
    logic [DIM_W-1:0] r_cfg_h;

    // Latched command.
    logic [15:0] r_u;
    logic [15:0] r_v;
    logic [15:0] r_rad;
    logic [7:0]  r_cr;
    logic [7:0]  r_cg;
    logic [7:0]  r_cb;
    logic [7:0]  r_ca;
    logic [7:0]  r_rx;
    logic [7:0]  r_ry;

    // Paint working state.
    logic [QW-1:0]    r_cx;
    logic [QW-1:0]    r_cy;
    logic [QW-1:0]    r_r;
    logic [D2W-1:0]   r_r2;
    logic [DIM_W-1:0] r_x0;
    logic [DIM_W-1:0] r_x1;
    logic [DIM_W-1:0] r_y1;
    logic [DIM_W-1:0] r_px;
    logic [DIM_W-1:0] r_py;
    logic             r_empty;
    logic [AW-1:0]    r_rowbase;
    logic [D2W-1:0]   r_d2x;
    logic [SW-1:0]    r_s;
    logic [SW*2-2:0]  r_t2;
    logic [15:0]      r_da;
    logic [31:0]      r_old;
    logic [7:0]       r_new [3];
    logic [1:0]       r_ch;

    // Fill working state.
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_last;

    // Result being built for the current command.
    logic [31:0]      r_pix;
    logic [7:0]       r_gx;
    logic [7:0]       r_gy;
    logic [DIM_W-1:0] r_gw;
    logic [DIM_W-1:0] r_gh;

    // Output register; it holds a finished result while the next command runs.
    logic             r_out_valid;
    logic [31:0]      r_o_pix;
    logic [7:0]       r_o_gx;
    logic [7:0]       r_o_gy;
    logic [DIM_W-1:0] r_o_gw;
    logic [DIM_W-1:0] r_o_gh;

    // Effective image size after clamping the registers.
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;

    always_comb begin
        if (r_cfg_w == '0) begin
            w = DIM_W'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w = DIM_W'(MAX_WIDTH);
        end else begin
            w = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h = DIM_W'(1);
        end else if (32'(r_cfg_h) > 32'(MAX_HEIGHT)) begin
            h = DIM_W'(MAX_HEIGHT);
        end else begin
            h = r_cfg_h;
        end
    end

    // Bounding box: floor of (c - r) and ceiling of (c + r), in whole pixels,
    // then clamped to the image.
    logic signed [QW+1:0] lo_x;
    logic signed [QW+1:0] lo_y;
    logic        [QW+1:0] hi_x;
    logic        [QW+1:0] hi_y;
    logic signed [QW-15:0] x0s;
    logic signed [QW-15:0] y0s;
    logic [QW-15:0] x0c;
    logic [QW-15:0] y0c;
    logic [QW-15:0] x1c;
    logic [QW-15:0] y1c;
    logic [QW-15:0] wm1;
    logic [QW-15:0] hm1;
    logic           box_empty;

    always_comb begin
        lo_x = $signed({2'b00, r_cx}) - $signed({2'b00, r_r});
        lo_y = $signed({2'b00, r_cy}) - $signed({2'b00, r_r});
        hi_x = {2'b00, r_cx} + {2'b00, r_r} + (QW+2)'(16'hFFFF);
        hi_y = {2'b00, r_cy} + {2'b00, r_r} + (QW+2)'(16'hFFFF);
        x0s  = lo_x[QW+1:16];
        y0s  = lo_y[QW+1:16];
        wm1  = (QW-14)'(w) - (QW-14)'(1);
        hm1  = (QW-14)'(h) - (QW-14)'(1);
        x0c  = (x0s < 0) ? '0 : x0s;
        y0c  = (y0s < 0) ? '0 : y0s;
        x1c  = (hi_x[QW+1:16] > wm1) ? wm1 : hi_x[QW+1:16];
        y1c  = (hi_y[QW+1:16] > hm1) ? hm1 : hi_y[QW+1:16];
        box_empty = (x1c < x0c) || (y1c < y0c);
    end

    // Distance of the current pixel from the center, per axis.
    logic signed [QW+1:0] dxs;
    logic signed [QW+1:0] dys;
    logic [QW-1:0] ax;
    logic [QW-1:0] ay;

    always_comb begin
        dxs = $signed({1'b0, r_px, 16'h0000}) - $signed({2'b00, r_cx});
        dys = $signed({1'b0, r_py, 16'h0000}) - $signed({2'b00, r_cy});
        ax  = QW'((dxs < 0) ? -dxs : dxs);
        ay  = QW'((dys < 0) ? -dys : dys);
    end

    // Shared multiplier.
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;

    rbp_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Channel selection and blend arithmetic.
    logic [D2W-1:0]    d2;
    logic              covered;
    logic [SW-1:0]     t;
    logic [7:0]        old_c;
    logic [7:0]        brush_c;
    logic              up;
    logic [7:0]        diff;
    logic [PROD_W-1:0] m;
    logic [PROD_W-1:0] m_adj;
    logic [16:0]       x;
    logic [9:0]        x_rem;
    logic [8:0]        q;
    logic [7:0]        new_c;

    always_comb begin
        d2      = r_d2x + D2W'(prod);
        covered = (d2 <= r_r2);
        t       = ONE_Q16 - r_s;
        old_c   = r_old[8*r_ch +: 8];
        case (r_ch)
            2'd0:    brush_c = r_cr;
            2'd1:    brush_c = r_cg;
            default: brush_c = r_cb;
        endcase
        up    = (brush_c >= old_c);
        diff  = up ? (brush_c - old_c) : (old_c - brush_c);
        // Full weight (t = 1.0) makes t squared one bit too wide for the
        // multiplier, so that product is formed by a shift.
        m     = r_t2[32] ? {16'h0000, r_da, 32'h0000_0000} : prod;
        m_adj = m + (up ? '0 : DEN_M1);
        x     = m_adj[48:32];
        // Divide by 255: x / 256 is low by at most one.
        x_rem = {2'b00, x[7:0]} + {1'b0, x[16:8]};
        q     = x[16:8] + ((x_rem >= 10'd255) ? 9'd1 : 9'd0);
        new_c = up ? (old_c + q[7:0]) : (old_c - q[7:0]);
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_F_N: begin
                mul_a = MUL_W'(w);
                mul_b = MUL_W'(h);
            end
            ST_R_ADDR: begin
                mul_a = MUL_W'(r_ry);
                mul_b = MUL_W'(w);
            end
            ST_P_CX: begin
                mul_a = MUL_W'(r_u);
                mul_b = MUL_W'(w);
            end
            ST_P_CY: begin
                mul_a = MUL_W'(ONE_Q16 - {1'b0, r_v});
                mul_b = MUL_W'(h);
            end
            ST_P_R: begin
                mul_a = MUL_W'(r_rad);
                mul_b = MUL_W'(w);
            end
            ST_P_R2: begin
                mul_a = MUL_W'(prod[QW-1:0]);
                mul_b = MUL_W'(prod[QW-1:0]);
            end
            ST_P_BOX: begin
                mul_a = MUL_W'(y0c);
                mul_b = MUL_W'(w);
            end
            ST_P_DX: begin
                mul_a = MUL_W'(ax);
                mul_b = MUL_W'(ax);
            end
            ST_P_DY: begin
                mul_a = MUL_W'(ay);
                mul_b = MUL_W'(ay);
            end
            ST_P_T2: begin
                mul_a = MUL_W'(t);
                mul_b = MUL_W'(t);
            end
            ST_P_DA: begin
                mul_a = MUL_W'(diff);
                mul_b = MUL_W'(r_ca);
            end
            ST_P_M: begin
                mul_a = MUL_W'(prod[15:0]);
                mul_b = r_t2[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Square root and normalization.
    t_sd_req  sd_req;
    t_sd_stat sd_stat;

    assign sd_req.start = (r_state == ST_P_CMP) && covered;
    assign sd_req.d2    = d2;
    assign sd_req.r     = r_r;

    rbp_sqrt_div u_sqrt_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sd_req),
        .o_stat  (sd_stat)
    );

    // Pixel store.
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [31:0]   st_wdata;
    logic [AW-1:0] st_raddr;
    logic [31:0]   st_rdata;
    logic [AW-1:0] pix_addr;

    always_comb begin
        pix_addr = r_rowbase + AW'(r_px);
        st_we    = (r_state == ST_F_RUN) || (r_state == ST_P_WR);
        if (r_state == ST_F_RUN) begin
            st_waddr = r_addr;
            st_wdata = {r_ca, r_cb, r_cg, r_cr};
        end else begin
            st_waddr = pix_addr;
            st_wdata = {r_old[31:24], r_new[2], r_new[1], r_new[0]};
        end
        st_raddr = (r_state == ST_R_RD) ? (AW'(prod) + AW'(r_rx)) : pix_addr;
    end

    rbp_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.pixel_rgba = r_o_pix;
    assign o_out.region_x   = r_o_gx;
    assign o_out.region_y   = r_o_gy;
    assign o_out.region_w   = r_o_gw;
    assign o_out.region_h   = r_o_gh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cfg_w     <= DIM_W'(256);
            r_cfg_h     <= DIM_W'(256);
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                    CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                    default:    ;
                endcase
            end

            // A new result enters the output register as the old one leaves.
            if ((r_state == ST_DONE) && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_u    <= i_in.center_u;
                        r_v    <= i_in.center_v;
                        r_rad  <= i_in.brush_radius;
                        r_cr   <= i_in.color_red;
                        r_cg   <= i_in.color_green;
                        r_cb   <= i_in.color_blue;
                        r_ca   <= i_in.color_alpha;
                        r_rx   <= i_in.read_x;
                        r_ry   <= i_in.read_y;
                        r_pix  <= '0;
                        r_gx   <= '0;
                        r_gy   <= '0;
                        r_gw   <= '0;
                        r_gh   <= '0;
                        unique case (i_in.func)
                            FUNC_PAINT: r_state <= ST_P_CX;
                            FUNC_FILL:  r_state <= ST_F_N;
                            FUNC_READ: begin
                                if (({1'b0, i_in.read_x} < w) &&
                                    ({1'b0, i_in.read_y} < h)) begin
                                    r_state <= ST_R_ADDR;
                                end else begin
                                    r_state <= ST_DONE;
                                end
                            end
                            default: r_state <= ST_DONE;
                        endcase
                    end
                end

                // Fill: write every pixel in use, one per cycle.
                ST_F_N: begin
                    r_gw    <= w;
                    r_gh    <= h;
                    r_state <= ST_F_SET;
                end
                ST_F_SET: begin
                    r_last  <= AW'(prod - PROD_W'(1));
                    r_addr  <= '0;
                    r_state <= ST_F_RUN;
                end
                ST_F_RUN: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == r_last) begin
                        r_state <= ST_DONE;
                    end
                end

                // Read: address from the multiplier, then one store read.
                ST_R_ADDR: r_state <= ST_R_RD;
                ST_R_RD:   r_state <= ST_R_CAP;
                ST_R_CAP: begin
                    r_pix   <= st_rdata;
                    r_state <= ST_DONE;
                end

                // Paint setup: center, radius, radius squared, box, row base.
                ST_P_CX: r_state <= ST_P_CY;
                ST_P_CY: begin
                    r_cx    <= prod[QW-1:0];
                    r_state <= ST_P_R;
                end
                ST_P_R: begin
                    r_cy    <= prod[QW-1:0];
                    r_state <= ST_P_R2;
                end
                ST_P_R2: begin
                    r_r     <= prod[QW-1:0];
                    r_state <= ST_P_BOX;
                end
                ST_P_BOX: begin
                    r_r2    <= prod[D2W-1:0];
                    r_x0    <= x0c[DIM_W-1:0];
                    r_x1    <= x1c[DIM_W-1:0];
                    r_y1    <= y1c[DIM_W-1:0];
                    r_px    <= x0c[DIM_W-1:0];
                    r_py    <= y0c[DIM_W-1:0];
                    r_empty <= box_empty;
                    if (!box_empty) begin
                        r_gx <= x0c[7:0];
                        r_gy <= y0c[7:0];
                        r_gw <= DIM_W'(x1c - x0c + (QW-14)'(1));
                        r_gh <= DIM_W'(y1c - y0c + (QW-14)'(1));
                    end
                    r_state <= ST_P_BASE;
                end
                ST_P_BASE: begin
                    r_rowbase <= AW'(prod);
                    r_state   <= r_empty ? ST_DONE : ST_P_DX;
                end

                // Per pixel: distance test, then, if covered, the blend of three channels.
                ST_P_DX: r_state <= ST_P_DY;
                ST_P_DY: begin
                    r_d2x   <= prod[D2W-1:0];
                    r_state <= ST_P_CMP;
                end
                ST_P_CMP: begin
                    r_old   <= st_rdata;
                    r_ch    <= 2'd0;
                    r_state <= covered ? ST_P_SD : ST_P_NEXT;
                end
                ST_P_SD: begin
                    if (sd_stat.done) begin
                        r_s     <= sd_stat.s;
                        r_state <= ST_P_T2;
                    end
                end
                ST_P_T2: r_state <= ST_P_DA;
                ST_P_DA: begin
                    if (r_ch == 2'd0) begin
                        r_t2 <= prod[SW*2-2:0];
                    end
                    r_state <= ST_P_M;
                end
                ST_P_M: begin
                    r_da    <= prod[15:0];
                    r_state <= ST_P_BL;
                end
                ST_P_BL: begin
                    r_new[r_ch] <= new_c;
                    if (r_ch == 2'd2) begin
                        r_state <= ST_P_WR;
                    end else begin
                        r_ch    <= r_ch + 2'd1;
                        r_state <= ST_P_DA;
                    end
                end
                ST_P_WR: r_state <= ST_P_NEXT;
                ST_P_NEXT: begin
                    if (r_px == r_x1) begin
                        if (r_py == r_y1) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_py      <= r_py + DIM_W'(1);
                            r_px      <= r_x0;
                            r_rowbase <= r_rowbase + AW'(w);
                            r_state   <= ST_P_DX;
                        end
                    end else begin
                        r_px    <= r_px + DIM_W'(1);
                        r_state <= ST_P_DX;
                    end
                end

                // Hand the result to the output register once it is free.
                ST_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_o_pix <= r_pix;
                        r_o_gx  <= r_gx;
                        r_o_gy  <= r_gy;
                        r_o_gw  <= r_gw;
                        r_o_gh  <= r_gh;
                        r_state <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
